>>> sv/asws_pkg.sv
// shared types and codes for the array store with search
package asws_pkg;

    // request modes
    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_LINEAR = 2'd2;
    localparam logic [1:0] MODE_BINARY = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_INDEX = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    // width of the used length register and of scan positions
    localparam int unsigned LEN_W = 9;

    // memory address source
    typedef enum logic [1:0] {
        ADDR_INDEX = 2'd0,
        ADDR_SCAN  = 2'd1,
        ADDR_MID   = 2'd2
    } addr_src_t;

    // kind of result to stage
    typedef enum logic [2:0] {
        RES_WRITE_OK  = 3'd0,
        RES_BAD_INDEX = 3'd1,
        RES_READ      = 3'd2,
        RES_LIN_HIT   = 3'd3,
        RES_BIN_HIT   = 3'd4,
        RES_MISS      = 3'd5
    } res_kind_t;

    // controller to datapath commands
    typedef struct packed {
        logic      capture;
        logic      mem_write;
        logic      mem_read;
        addr_src_t addr_src;
        logic      scan_start;
        logic      scan_step;
        logic      bin_start;
        logic      bin_step;
        logic      res_load;
        res_kind_t res_kind;
        logic      out_load;
    } asws_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] req_mode;
        logic       index_ok;
        logic       len_zero;
        logic       lin_hit;
        logic       lin_last;
        logic       bin_empty;
        logic       bin_hit;
        logic       out_free;
    } asws_stat_t;

endpackage

>>> sv/array_store_with_search_core.sv
// Word store with write, read, linear search and binary search, one request at a time.
// A request is taken when s_valid and s_ready are high and gives one result transfer
// on the m_ channel; the next request is taken as soon as the previous result sits in
// the output register. All work goes through one single-port entry memory with a
// registered read, one access per cycle, and that port sets the pace: a write stores
// its word while the request is decoded, a read waits for the registered read, a
// linear search reads the entries in order from position 0 and stops at the first
// match or after the last used entry, and a binary search reads the midpoint of the
// remaining range per probe until a hit or an empty range. With a used length of zero
// a search answers not found and a read a bad index, without reading the memory. A
// result held by a low m_ready delays the next request.
// cfg_wr_en loads the used length (reset value 1, saturated to DEPTH) and is meant to
// be written while no request is in flight. Binary search expects the used entries in
// ascending signed order. Entries read before they are written return unknown data.
module array_store_with_search_core #(
    parameter int unsigned DEPTH     = 256,
    parameter int unsigned WORD_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_index,
    input  logic [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [7:0]  m_position,
    output logic [31:0] m_read_value
);
    import asws_pkg::*;

    asws_cmd_t  cmd;
    asws_stat_t stat;

    // sequencer
    asws_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // memory and datapath
    asws_dpath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_mode       (s_mode),
        .s_index      (s_index),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_position   (m_position),
        .m_read_value (m_read_value),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

>>> sv/asws_ctrl.sv
// request sequencer for the array store with search
module asws_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  asws_pkg::asws_stat_t stat,
    output asws_pkg::asws_cmd_t  cmd
);
    import asws_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DECODE   = 7'b0000010,
        S_RD_WAIT  = 7'b0000100,
        S_LIN      = 7'b0001000,
        S_BIN_ADDR = 7'b0010000,
        S_BIN_CMP  = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    // next state and command decode
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.addr_src = ADDR_INDEX;
        cmd.res_kind = RES_WRITE_OK;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (stat.req_mode)
                    MODE_WRITE: begin
                        cmd.mem_write = stat.index_ok;
                        cmd.res_load  = 1'b1;
                        cmd.res_kind  = stat.index_ok ? RES_WRITE_OK : RES_BAD_INDEX;
                        state_next    = S_DONE;
                    end
                    MODE_READ: begin
                        if (stat.index_ok) begin
                            cmd.mem_read = 1'b1;
                            cmd.addr_src = ADDR_INDEX;
                            state_next   = S_RD_WAIT;
                        end else begin
                            cmd.res_load = 1'b1;
                            cmd.res_kind = RES_BAD_INDEX;
                            state_next   = S_DONE;
                        end
                    end
                    MODE_LINEAR: begin
                        if (stat.len_zero) begin
                            cmd.res_load = 1'b1;
                            cmd.res_kind = RES_MISS;
                            state_next   = S_DONE;
                        end else begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_LIN;
                        end
                    end
                    MODE_BINARY: begin
                        if (stat.len_zero) begin
                            cmd.res_load = 1'b1;
                            cmd.res_kind = RES_MISS;
                            state_next   = S_DONE;
                        end else begin
                            cmd.bin_start = 1'b1;
                            state_next    = S_BIN_ADDR;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_RD_WAIT: begin
                cmd.res_load = 1'b1;
                cmd.res_kind = RES_READ;
                state_next   = S_DONE;
            end
            // one read issued and one compare done per cycle
            S_LIN: begin
                if (stat.lin_hit) begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_LIN_HIT;
                    state_next   = S_DONE;
                end else if (stat.lin_last) begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_MISS;
                    state_next   = S_DONE;
                end else begin
                    cmd.scan_step = 1'b1;
                    cmd.addr_src  = ADDR_SCAN;
                end
            end
            S_BIN_ADDR: begin
                if (stat.bin_empty) begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_MISS;
                    state_next   = S_DONE;
                end else begin
                    cmd.mem_read = 1'b1;
                    cmd.addr_src = ADDR_MID;
                    state_next   = S_BIN_CMP;
                end
            end
            S_BIN_CMP: begin
                if (stat.bin_hit) begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_BIN_HIT;
                    state_next   = S_DONE;
                end else begin
                    cmd.bin_step = 1'b1;
                    state_next   = S_BIN_ADDR;
                end
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/asws_dpath.sv
// entry memory, search counters, compare logic and result register
module asws_dpath #(
    parameter int unsigned DEPTH     = 256,
    parameter int unsigned WORD_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [8:0]            cfg_wr_data,
    input  logic [1:0]            s_mode,
    input  logic [7:0]            s_index,
    input  logic [31:0]           s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_status,
    output logic [7:0]            m_position,
    output logic [31:0]           m_read_value,
    input  asws_pkg::asws_cmd_t   cmd,
    output asws_pkg::asws_stat_t  stat
);
    import asws_pkg::*;

    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned EXT_W  = (ADDR_W > LEN_W) ? ADDR_W : LEN_W;
    localparam logic [LEN_W-1:0] DEPTH_CAP =
        (DEPTH > 511) ? 9'd511 : LEN_W'(DEPTH);

    // entry memory
    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    // configuration and captured request
    logic [LEN_W-1:0]     used_length_reg;
    logic [1:0]           mode_reg;
    logic [7:0]           index_reg;
    logic [WORD_BITS-1:0] key_reg;

    // linear scan state
    logic [LEN_W-1:0]     scan_reg;
    logic [LEN_W-1:0]     cmp_pos_reg;
    logic                 cmp_valid_reg;

    // binary search range
    logic signed [10:0]   lo_reg;
    logic signed [10:0]   hi_reg;

    // staged result and output register
    logic [1:0]           res_status_reg;
    logic [LEN_W-1:0]     res_pos_reg;
    logic [WORD_BITS-1:0] res_data_reg;
    logic                 m_valid_reg;
    logic [1:0]           m_status_reg;
    logic [7:0]           m_position_reg;
    logic [31:0]          m_read_value_reg;

    logic [LEN_W-1:0]     len;
    logic [63:0]          value_ext;
    logic signed [10:0]   range_sum;
    logic [LEN_W-1:0]     mid;
    logic [LEN_W-1:0]     addr_pick;
    logic [EXT_W-1:0]     addr_ext;
    logic [ADDR_W-1:0]    mem_addr;
    logic                 scan_ok;
    logic [63:0]          rd_ext;

    // effective used length, saturated to the memory depth
    assign len = (32'(used_length_reg) > DEPTH) ? DEPTH_CAP : used_length_reg;

    // input word: sign extend, then cut to the word width
    assign value_ext = {{32{s_value[31]}}, s_value};

    // midpoint of the inclusive range
    assign range_sum = lo_reg + hi_reg;
    assign mid       = range_sum[LEN_W:1];

    assign scan_ok = (scan_reg < len);

    // address selection
    always_comb begin
        case (cmd.addr_src)
            ADDR_SCAN: addr_pick = scan_reg;
            ADDR_MID:  addr_pick = mid;
            default:   addr_pick = {1'b0, index_reg};
        endcase
    end
    assign addr_ext = EXT_W'(addr_pick);
    assign mem_addr = addr_ext[ADDR_W-1:0];

    // memory write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.mem_write) begin
            mem[mem_addr] <= key_reg;
        end
        if (cmd.mem_read || (cmd.scan_step && scan_ok)) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_length_reg <= LEN_W'(1);
        end else if (cfg_wr_en) begin
            used_length_reg <= cfg_wr_data;
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg  <= s_mode;
            index_reg <= s_index;
            key_reg   <= value_ext[WORD_BITS-1:0];
        end
    end

    // linear scan counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_valid_reg <= 1'b0;
        end else if (cmd.scan_start) begin
            cmp_valid_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            cmp_valid_reg <= scan_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            scan_reg    <= '0;
            cmp_pos_reg <= '0;
        end else if (cmd.scan_step && scan_ok) begin
            scan_reg    <= scan_reg + LEN_W'(1);
            cmp_pos_reg <= scan_reg;
        end
    end

    // binary search range update
    always_ff @(posedge aclk) begin
        if (cmd.bin_start) begin
            lo_reg <= '0;
            hi_reg <= $signed({2'b00, len}) - 11'sd1;
        end else if (cmd.bin_step) begin
            if ($signed(rd_data_reg) > $signed(key_reg)) begin
                hi_reg <= $signed({2'b00, mid}) - 11'sd1;
            end else begin
                lo_reg <= $signed({2'b00, mid}) + 11'sd1;
            end
        end
    end

    // status back to the controller
    always_comb begin
        stat.req_mode  = mode_reg;
        stat.index_ok  = (mode_reg == MODE_WRITE) ? (32'(index_reg) < DEPTH)
                                                  : ({1'b0, index_reg} < len);
        stat.len_zero  = (len == '0);
        stat.lin_hit   = cmp_valid_reg && (rd_data_reg == key_reg);
        stat.lin_last  = cmp_valid_reg && (cmp_pos_reg == len - LEN_W'(1));
        stat.bin_empty = (lo_reg > hi_reg);
        stat.bin_hit   = (rd_data_reg == key_reg);
        stat.out_free  = !m_valid_reg || m_ready;
    end

    // staged result
    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            res_status_reg <= STATUS_OK;
            res_pos_reg    <= '0;
            res_data_reg   <= '0;
            case (cmd.res_kind)
                RES_BAD_INDEX: res_status_reg <= STATUS_BAD_INDEX;
                RES_READ:      res_data_reg   <= rd_data_reg;
                RES_LIN_HIT:   res_pos_reg    <= cmp_pos_reg;
                RES_BIN_HIT:   res_pos_reg    <= mid;
                RES_MISS:      res_status_reg <= STATUS_NOT_FOUND;
                default:       res_status_reg <= STATUS_OK;
            endcase
        end
    end

    // entry word zero extended to the output width
    assign rd_ext = 64'(res_data_reg);

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg     <= res_status_reg;
            m_position_reg   <= res_pos_reg[7:0];
            m_read_value_reg <= rd_ext[31:0];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_position   = m_position_reg;
    assign m_read_value = m_read_value_reg;

endmodule
